/* rtl/core/sorted_set_table_core_macros.svh */
// ----------------------------------------------------------------------------
// sorted_set_table_core_macros.svh
// Assertion macros for the sorted set table core.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef SORTED_SET_TABLE_CORE_MACROS_SVH
`define SORTED_SET_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SST_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SST_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SST_ASSERT_IMP(name, ante, cons, msg)
`define SST_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

/* rtl/core/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// Capacity, request and status codes and cell control type for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SST_CAPACITY = 16;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_MEMBER = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_BOUNDS    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

endpackage

/* rtl/core/sorted_set_table_core.sv */
// ----------------------------------------------------------------------------
// sorted_set_table_core
// Ordered set of distinct signed 32-bit values with insert, delete,
// membership test and read by rank.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, value and rank_index; the request beat is
// taken at an edge where start is high and busy is low. busy is high in the
// cycle after acceptance, while the chain of cells shifts. The result
// beat (status, found, read_value, element_count) is shown for exactly one
// cycle with done high, in the cycle after the busy cycle, and is taken at
// the edge that ends that cycle. A new request may be given in the cycle where
// done is high, so the block takes a new request while the last result is
// shown, but never while busy is high. Every cell compares its entry with
// the value in the accept cycle, and the shift plus the wide OR for presence
// take place in the busy cycle.
// The receiver has no back pressure; each result beat must be taken when
// done is high. Reset clears the element count, busy and done; entries are
// not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "sorted_set_table_core_macros.svh"

module sorted_set_table_core
#(
    parameter int CAPACITY = sst_pkg::SST_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [3:0]         rank_index,
    output logic               done,
    output logic [2:0]         status,
    output logic               found,
    output logic signed [31:0] read_value,
    output logic [4:0]         element_count
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [1:0]          req_reg;
    logic signed [31:0]  val_reg;
    logic [3:0]          rank_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [2:0]          status_reg;
    logic [2:0]          status_next;
    logic                found_reg;
    logic                found_next;
    logic signed [31:0]  rd_reg;
    logic signed [31:0]  rd_next;
    logic [4:0]          ecount_reg;

    logic                accept;
    logic                present;
    logic                full;
    logic                out_of_range;
    logic [CNT_W+4:0]    count_wide;
    cell_ctrl_t          ctrl;

    logic signed [31:0]  entry_q [CAPACITY];
    logic [CAPACITY-1:0] less_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic signed [31:0]  rank_view [16];

    assign accept = start && !busy_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] left_e;
            logic               left_l;
            logic signed [31:0] right_e;
            logic               occ;

            if (gi == 0)
            begin : g_first
                assign left_e = val_reg;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = entry_q[gi-1];
                assign left_l = less_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_e = entry_q[gi];
            end
            else
            begin : g_inner
                assign right_e = entry_q[gi+1];
            end

            assign occ = (CNT_W'(gi) < count_reg);

            sst_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ),
                .value       (value),
                .ins_value   (val_reg),
                .left_entry  (left_e),
                .left_less   (left_l),
                .right_entry (right_e),
                .entry       (entry_q[gi]),
                .less        (less_vec[gi]),
                .eq          (eq_vec[gi])
            );
        end

        // Rank reads reach only the first sixteen slots.
        for (gi = 0; gi < 16; gi++)
        begin : g_rank
            if (gi < CAPACITY)
            begin : g_used
                assign rank_view[gi] = entry_q[gi];
            end
            else
            begin : g_none
                assign rank_view[gi] = '0;
            end
        end
    endgenerate

    assign present      = |eq_vec;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign out_of_range = ((CNT_W+4)'(rank_reg) >= (CNT_W+4)'(count_reg));

    always_comb
    begin
        ctrl.cmp_en = accept;
        ctrl.ins_en = busy_reg && (req_reg == REQ_INSERT) && !present && !full;
        ctrl.del_en = busy_reg && (req_reg == REQ_DELETE) && present;
    end

    always_comb
    begin
        status_next = ST_OK;
        found_next  = 1'b0;
        rd_next     = '0;
        count_next  = count_reg;
        case (req_reg)
            REQ_INSERT:
            begin
                if (present)
                begin
                    status_next = ST_DUP;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (present)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_MEMBER:
            begin
                found_next = present;
            end
            REQ_READ:
            begin
                if (out_of_range)
                begin
                    status_next = ST_BOUNDS;
                end
                else
                begin
                    rd_next = rank_view[rank_reg];
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign count_wide = (CNT_W+5)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            val_reg  <= value;
            rank_reg <= rank_index;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            rd_reg     <= rd_next;
            ecount_reg <= count_wide[4:0];
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign read_value    = rd_reg;
    assign element_count = ecount_reg;

    `SST_ASSERT_NXT(a_busy_one_cycle, busy_reg, !busy_reg && done_reg, "busy held too long")
    `SST_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count past capacity")
    `SST_ASSERT_NXT(a_insert_count, ctrl.ins_en, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `SST_ASSERT_IMP(a_found_status, done_reg && found_reg, status_reg == ST_OK, "found with bad status")
    `SST_ASSERT_IMP(a_shift_exclusive, busy_reg, !(ctrl.ins_en && ctrl.del_en) && !ctrl.cmp_en, "shift enables clash")

endmodule

/* rtl/core/sst_cell.sv */
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted chain: holds an entry, compares it with the
// request value and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sst_cell
(
    input  logic                clk,
    input  sst_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  ins_value,
    input  logic signed [31:0]  left_entry,
    input  logic                left_less,
    input  logic signed [31:0]  right_entry,
    output logic signed [31:0]  entry,
    output logic                less,
    output logic                eq
);
    import sst_pkg::*;

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               less_reg;
    logic               eq_reg;

    // On insert, cells below the insertion point keep their entry; the first cell
    // at or above it takes the new value and the rest take their left neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en && !less_reg)
        begin
            entry_next = left_less ? ins_value : left_entry;
        end
        else if (ctrl.del_en && !less_reg)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.cmp_en)
        begin
            less_reg <= occupied && (entry_reg < value);
            eq_reg   <= occupied && (entry_reg == value);
        end
    end

    assign entry = entry_reg;
    assign less  = less_reg;
    assign eq    = eq_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for sorted_set_table_core. A table of directed requests walks
// the empty, extreme and full cases, then random requests swing the set
// between empty and full under three idling patterns on the request side.
// Result beats are checked against a model of the ordered set or a pinned row.
// ----------------------------------------------------------------------------
module testbench;

    import sst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 340;
    localparam int POOL_SIZE   = 8;

    typedef struct packed {
        logic [2:0]         status;
        logic               found;
        logic signed [31:0] read_value;
        logic [4:0]         element_count;
    } set_result_t;

    typedef struct packed {
        logic [1:0]         req;
        logic signed [31:0] val;
        logic [3:0]         rank;
        logic               pinned;
        set_result_t        result;
    } dir_row_t;

    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;
    localparam int DIR_ROWS = 28;

    // Rows with pinned set carry the result that must come back; the others
    // are checked against the predictor only.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{REQ_READ,   32'sd0,          4'd0,  1'b1, '{ST_BOUNDS,    1'b0, 32'sd0, 5'd0}},
        '{REQ_DELETE, 32'sd0,          4'd0,  1'b1, '{ST_NOT_FOUND, 1'b0, 32'sd0, 5'd0}},
        '{REQ_INSERT, VMAX,            4'd0,  1'b1, '{ST_OK,        1'b0, 32'sd0, 5'd1}},
        '{REQ_INSERT, VMIN,            4'd0,  1'b1, '{ST_OK,        1'b0, 32'sd0, 5'd2}},
        '{REQ_INSERT, VMIN,            4'd0,  1'b1, '{ST_DUP,       1'b0, 32'sd0, 5'd2}},
        '{REQ_READ,   32'sd0,          4'd1,  1'b1, '{ST_OK,        1'b0, VMAX,   5'd2}},
        '{REQ_DELETE, VMIN,            4'd0,  1'b1, '{ST_OK,        1'b0, 32'sd0, 5'd1}},
        '{REQ_MEMBER, VMIN,            4'd0,  1'b1, '{ST_OK,        1'b0, 32'sd0, 5'd1}},
        '{REQ_INSERT, -32'sd1,         4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sd0,          4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sd1,          4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sh5555_5555,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'shAAAA_AAAA,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sh0F0F_0F0F,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'shF0F0_F0F0,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sh8000_0001,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sh7FFF_FFFE,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sd2,          4'd0,  1'b0, '0},
        '{REQ_INSERT, -32'sd2,         4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sh1234_5678,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'shEDCB_A988,  4'd0,  1'b0, '0},
        '{REQ_INSERT, 32'sd100,        4'd0,  1'b0, '0},
        '{REQ_INSERT, -32'sd100,       4'd0,  1'b1, '{ST_OK,        1'b0, 32'sd0, 5'd16}},
        '{REQ_INSERT, VMIN,            4'd0,  1'b1, '{ST_FULL,      1'b0, 32'sd0, 5'd16}},
        '{REQ_INSERT, VMAX,            4'd0,  1'b1, '{ST_DUP,       1'b0, 32'sd0, 5'd16}},
        '{REQ_READ,   32'sd0,          4'd15, 1'b1, '{ST_OK,        1'b0, VMAX,   5'd16}},
        '{REQ_DELETE, 32'sh8000_0001,  4'd0,  1'b1, '{ST_OK,        1'b0, 32'sd0, 5'd15}},
        '{REQ_MEMBER, 32'sd0,          4'd0,  1'b1, '{ST_OK,        1'b1, 32'sd0, 5'd15}}
    };

    localparam logic signed [31:0] VALUE_POOL [POOL_SIZE] = '{
        VMIN, VMAX, 32'sd0, -32'sd1, 32'sd1, 32'sd7, -32'sd7, 32'sh4000_0000
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic signed [31:0] value;
    logic [3:0]         rank_index;
    logic               done;
    logic [2:0]         status;
    logic               found;
    logic signed [31:0] read_value;
    logic [4:0]         element_count;

    // Pinned expectation travels with the request fields.
    logic               pin_on;
    set_result_t        pin_result;

    logic signed [31:0] held [SST_CAPACITY];
    int                 held_count;
    set_result_t        pending_results [$];
    int                 errors;
    int                 gap_pct;
    int                 cycles;

    sorted_set_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .value         (value),
        .rank_index    (rank_index),
        .done          (done),
        .status        (status),
        .found         (found),
        .read_value    (read_value),
        .element_count (element_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the model set and returns the result it yields.
    function automatic set_result_t apply_request(input logic [1:0] r,
                                                  input logic signed [31:0] v,
                                                  input logic [3:0] k);
        set_result_t res;
        int          pos;
        bit          present;
        res = '0;
        pos = 0;
        while (pos < held_count && held[pos] < v)
            pos++;
        present = (pos < held_count) && (held[pos] == v);
        case (r)
            REQ_INSERT:
            begin
                if (present)
                    res.status = ST_DUP;
                else if (held_count >= SST_CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (int j = held_count; j > pos; j--)
                        held[j] = held[j - 1];
                    held[pos] = v;
                    held_count++;
                end
            end
            REQ_DELETE:
            begin
                if (!present)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = pos; j < held_count - 1; j++)
                        held[j] = held[j + 1];
                    held_count--;
                end
            end
            REQ_MEMBER:
                res.found = present;
            default:
            begin
                if (int'(k) >= held_count)
                    res.status = ST_BOUNDS;
                else
                    res.read_value = held[k];
            end
        endcase
        res.element_count = 5'(held_count);
        return res;
    endfunction

    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        errors++;
                    end
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d got %0d", $time, want.found, found);
                        errors++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %0d got %0d", $time,
                                 want.read_value, read_value);
                        errors++;
                    end
                    if (element_count !== want.element_count)
                    begin
                        $display("%0t: element_count expected %0d got %0d", $time,
                                 want.element_count, element_count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = apply_request(req_type, value, rank_index);
                if (pin_on)
                    want = pin_result;
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sorted_set_table_core regression: fail");
            $finish;
        end
    end

    // Presents one request beat and returns once the block has taken it.
    task automatic send_request(input logic [1:0] r, input logic signed [31:0] v,
                                input logic [3:0] k, input logic pin,
                                input set_result_t pres);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        req_type   <= r;
        value      <= v;
        rank_index <= k;
        pin_on     <= pin;
        pin_result <= pres;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic [1:0]         r;
        logic signed [31:0] v;
        int                 roll;
        bit                 filling;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_INSERT;
        value      = '0;
        rank_index = '0;
        pin_on     = 1'b0;
        pin_result = '0;
        held_count = 0;
        errors     = 0;
        cycles     = 0;
        gap_pct    = 0;
        for (int i = 0; i < SST_CAPACITY; i++)
            held[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(DIRECTED[i].req, DIRECTED[i].val, DIRECTED[i].rank,
                         DIRECTED[i].pinned, DIRECTED[i].result);

        // Random part: the bias alternates between filling and draining the
        // set so that both the empty and the full store are visited often.
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 34 : (phase == 1) ? 53 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                filling = ((i / 50) % 2) == 0;
                roll = $urandom_range(99);
                if (filling)
                    r = (roll < 55) ? REQ_INSERT : (roll < 70) ? REQ_DELETE :
                        (roll < 85) ? REQ_MEMBER : REQ_READ;
                else
                    r = (roll < 15) ? REQ_INSERT : (roll < 60) ? REQ_DELETE :
                        (roll < 80) ? REQ_MEMBER : REQ_READ;
                case ($urandom_range(3))
                    0: v = VALUE_POOL[$urandom_range(POOL_SIZE - 1)];
                    1: v = (held_count > 0) ? held[$urandom_range(held_count - 1)]
                                            : $urandom;
                    default: v = $urandom;
                endcase
                send_request(r, v, 4'($urandom_range(15)), 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("sorted_set_table_core regression: pass");
        else
            $display("sorted_set_table_core regression: fail");
        $finish;
    end

endmodule
